// ----- design/shot_latency_tracker_top_defines.svh -----
// Assertion macros for the shot latency tracker.
// Included by the port checker; needs nothing else.
`ifndef SHOT_LATENCY_TRACKER_TOP_DEFINES_SVH
`define SHOT_LATENCY_TRACKER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset
`define SLT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("shot latency tracker check failed");

// Next-cycle implication, clocked on i_clk, off during reset
`define SLT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("shot latency tracker check failed");

`endif

// ----- design/slt_pkg.sv -----
// Shared types and constants for the shot latency tracker.
// Used by the controller, the datapath and the top level.
package slt_pkg;

    // Ring depth default and register reset values
    localparam int          RING_DEPTH_DEF = 8;
    localparam logic [15:0] TIMEOUT_RST    = 16'd500;
    localparam logic [15:0] THRESH_RST     = 16'd0;

    // Config port
    localparam int         CFG_IDX_W   = 1;
    localparam logic [0:0] CFG_TIMEOUT = 1'b0;
    localparam logic [0:0] CFG_THRESH  = 1'b1;

    // Request modes
    localparam logic [1:0] MODE_FIRE  = 2'd0;
    localparam logic [1:0] MODE_CHECK = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_TEST,
        S_WAIT,
        S_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic do_fire;
        logic do_clear;
        logic pop_timeout;
        logic eval;
        logic emit;
    } t_slt_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       count_zero;
        logic       age_over;
        logic       slot_free;
    } t_slt_stat;

endpackage

// ----- design/slt_ctrl.sv -----
// Controller state machine for the shot latency tracker.
// Depends on slt_pkg; drives commands into slt_dp.
module slt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  slt_pkg::t_slt_stat i_stat,
    output slt_pkg::t_slt_cmd  o_cmd
);
    import slt_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.mode)
                    MODE_FIRE: begin
                        o_cmd.do_fire = 1'b1;
                        n_state       = S_EMIT;
                    end
                    MODE_CHECK: begin
                        n_state = S_TEST;
                    end
                    MODE_CLEAR: begin
                        o_cmd.do_clear = 1'b1;
                        n_state        = S_EMIT;
                    end
                    default: begin
                        n_state = S_EMIT;
                    end
                endcase
            end
            S_TEST: begin
                // drop stale head entries one at a time, then judge the speed
                if (!i_stat.count_zero && i_stat.age_over) begin
                    o_cmd.pop_timeout = 1'b1;
                    n_state           = S_WAIT;
                end else begin
                    o_cmd.eval = 1'b1;
                    n_state    = S_EMIT;
                end
            end
            S_WAIT: begin
                // new head stamp comes out of the ring read register
                n_state = S_TEST;
            end
            S_EMIT: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/slt_dp.sv -----
// Datapath of the shot latency tracker: stamp ring, counters, config and
// the output register. Depends on slt_pkg; steered by slt_ctrl.
module slt_dp #(
    parameter int RING_DEPTH = slt_pkg::RING_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [1:0]                    i_mode,
    input  logic [31:0]                   i_now_ms,
    input  logic [15:0]                   i_speed_code,
    input  logic                          i_cfg_valid,
    input  logic [slt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    input  logic                          i_out_stall,
    input  slt_pkg::t_slt_cmd             i_cmd,
    output slt_pkg::t_slt_stat            o_stat,
    output logic                          o_out_valid,
    output logic                          o_delay_valid,
    output logic [15:0]                   o_delay_ms,
    output logic [3:0]                    o_pending_count,
    output logic [31:0]                   o_fire_count,
    output logic [31:0]                   o_update_count,
    output logic [31:0]                   o_overflow_count,
    output logic [31:0]                   o_timeout_count
);
    import slt_pkg::*;

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RING_DEPTH);

    // Captured request
    logic [1:0]  r_mode;
    logic [31:0] r_now;
    logic [15:0] r_speed;

    // Config registers
    logic [15:0] r_timeout;
    logic [15:0] r_thresh;

    // Ring and its pointers
    logic [31:0]      r_ring [RING_DEPTH];
    logic [31:0]      r_rd_data;
    logic [IDX_W-1:0] r_head;
    logic [IDX_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;

    // Tracker state
    logic [15:0] r_ref;
    logic [31:0] r_fires;
    logic [31:0] r_upd;
    logic [31:0] r_ovf;
    logic [31:0] r_tmo;
    logic        r_dvalid;
    logic [15:0] r_delay;

    // Output register
    logic        r_out_valid;
    logic        r_o_dvalid;
    logic [15:0] r_o_delay;
    logic [3:0]  r_o_pending;
    logic [31:0] r_o_fires;
    logic [31:0] r_o_upd;
    logic [31:0] r_o_ovf;
    logic [31:0] r_o_tmo;

    logic [IDX_W-1:0] n_head;
    logic [IDX_W-1:0] n_tail;
    logic [31:0]      age;
    logic [15:0]      diff;
    logic             count_zero;
    logic             full;
    logic             diff_over;
    logic [CNT_W+3:0] count_ext;

    // Combinational helpers
    always_comb begin
        n_head     = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
        n_tail     = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
        age        = r_now - r_rd_data;
        diff       = (r_speed > r_ref) ? (r_speed - r_ref) : (r_ref - r_speed);
        count_zero = (r_count == '0);
        full       = (r_count == FULL_CNT);
        diff_over  = (diff > r_thresh);
        count_ext  = {4'b0000, r_count};
    end

    assign o_stat.mode       = r_mode;
    assign o_stat.count_zero = count_zero;
    assign o_stat.age_over   = (age > {16'h0000, r_timeout});
    assign o_stat.slot_free  = !r_out_valid || !i_out_stall;

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_now   <= i_now_ms;
            r_speed <= i_speed_code;
        end
    end

    // Ring write at the tail, registered read at the head
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_fire) begin
            r_ring[r_tail] <= r_now;
        end
        r_rd_data <= r_ring[r_head];
    end

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_thresh  <= THRESH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TIMEOUT: r_timeout <= i_cfg_data;
                CFG_THRESH:  r_thresh  <= i_cfg_data;
                default:     r_thresh  <= r_thresh;
            endcase
        end
    end

    // Ring pointers, reference speed and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_ref    <= '0;
            r_fires  <= '0;
            r_upd    <= '0;
            r_ovf    <= '0;
            r_tmo    <= '0;
            r_dvalid <= 1'b0;
            r_delay  <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_dvalid <= 1'b0;
                r_delay  <= '0;
            end
            if (i_cmd.do_fire) begin
                if (count_zero) begin
                    r_ref <= r_speed;
                end
                // full ring: oldest entry gives way
                if (full) begin
                    r_head <= n_head;
                    r_ovf  <= r_ovf + 32'd1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
                r_tail  <= n_tail;
                r_fires <= r_fires + 32'd1;
            end
            if (i_cmd.do_clear) begin
                r_head  <= '0;
                r_tail  <= '0;
                r_count <= '0;
                r_upd   <= '0;
                r_ovf   <= '0;
                r_tmo   <= '0;
                r_ref   <= r_speed;
            end
            if (i_cmd.pop_timeout) begin
                r_head  <= n_head;
                r_count <= r_count - 1'b1;
                r_tmo   <= r_tmo + 32'd1;
            end
            // speed change: measure against the oldest pending fire
            if (i_cmd.eval && diff_over) begin
                r_ref <= r_speed;
                if (!count_zero) begin
                    r_delay  <= age[15:0];
                    r_dvalid <= 1'b1;
                    r_upd    <= r_upd + 32'd1;
                    r_head   <= n_head;
                    r_count  <= r_count - 1'b1;
                end
            end
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_dvalid  <= r_dvalid;
            r_o_delay   <= r_delay;
            r_o_pending <= count_ext[3:0];
            r_o_fires   <= r_fires;
            r_o_upd     <= r_upd;
            r_o_ovf     <= r_ovf;
            r_o_tmo     <= r_tmo;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_delay_valid    = r_o_dvalid;
    assign o_delay_ms       = r_o_delay;
    assign o_pending_count  = r_o_pending;
    assign o_fire_count     = r_o_fires;
    assign o_update_count   = r_o_upd;
    assign o_overflow_count = r_o_ovf;
    assign o_timeout_count  = r_o_tmo;

endmodule

// ----- design/shot_latency_tracker_top.sv -----
// Top level of the shot latency tracker: controller plus datapath.
// Depends on slt_pkg, slt_ctrl and slt_dp.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------
//   in      | in        | i_in_valid/o_in_stall  | i_mode, i_now_ms, i_speed_code
//   out     | out       | o_out_valid/i_out_stall| o_delay_valid ... o_timeout_count
//   cfg     | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// One request at a time. Fire, clear and unused modes go from dispatch to
// emit; a check goes through the test state, with a wait state for each
// timed-out entry dropped, for the registered ring read at the head pointer.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled result is held in the output register while the next
// request is accepted; its processing then waits on that register.
module shot_latency_tracker_top #(
    parameter int RING_DEPTH = slt_pkg::RING_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_mode,
    input  logic [31:0]                   i_now_ms,
    input  logic [15:0]                   i_speed_code,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_delay_valid,
    output logic [15:0]                   o_delay_ms,
    output logic [3:0]                    o_pending_count,
    output logic [31:0]                   o_fire_count,
    output logic [31:0]                   o_update_count,
    output logic [31:0]                   o_overflow_count,
    output logic [31:0]                   o_timeout_count,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [slt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);
    import slt_pkg::*;

    t_slt_cmd  cmd;
    t_slt_stat stat;

    // Config writes are always accepted
    assign o_cfg_ready = 1'b1;

    slt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    slt_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_mode           (i_mode),
        .i_now_ms         (i_now_ms),
        .i_speed_code     (i_speed_code),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_out_stall      (i_out_stall),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_out_valid      (o_out_valid),
        .o_delay_valid    (o_delay_valid),
        .o_delay_ms       (o_delay_ms),
        .o_pending_count  (o_pending_count),
        .o_fire_count     (o_fire_count),
        .o_update_count   (o_update_count),
        .o_overflow_count (o_overflow_count),
        .o_timeout_count  (o_timeout_count)
    );

endmodule

// ----- design/slt_checker.sv -----
// Port-level checks for the shot latency tracker, bound to the top level.
// Depends on shot_latency_tracker_top_defines.svh.
`include "shot_latency_tracker_top_defines.svh"

module slt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_delay_valid,
    input logic [15:0] o_delay_ms,
    input logic [31:0] o_fire_count
);

    // A held result keeps its valid and its contents
    `SLT_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_delay_ms) && $stable(o_fire_count))

    // No measurement means a zero delay
    `SLT_ASSERT_NOW(a_delay_zero, o_out_valid && !o_delay_valid, o_delay_ms == 16'd0)

    // One request in flight: an accepted request closes the input
    `SLT_ASSERT_NEXT(a_one_in_flight, i_in_valid && !o_in_stall, o_in_stall)

endmodule

bind shot_latency_tracker_top slt_checker u_slt_checker (.*);
